[src/csl_pkg.sv]
// Shared types and codes for the cursor slot cache.
package csl_pkg;

    // Request codes carried on the action field
    localparam logic [1:0] ACT_SHOW    = 2'd0;
    localparam logic [1:0] ACT_RELEASE = 2'd1;
    localparam logic [1:0] ACT_FLUSH   = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_COMMIT
    } state_t;

endpackage

[src/cursor_slot_lru_cache_core.sv]
// Cursor slot cache top level: request channel, slot scan, commit and result register.
//
// Usage:
//   Request words (action, cursor_id, large_req) enter on in_valid/in_stall;
//   one result word per request (slot, hit, load_needed, flushed_all,
//   evicted_valid, evicted_id) leaves on out_valid/out_stall.
//   Slot owners and stamps live in a one-port-read, one-port-write memory
//   with a registered read port; valid bits and the virtual clock are
//   flops. Each request scans all slots one read per cycle, then commits.
// Sequence:
//   A request passes through the serial memory scan, a drain state and a
//   commit state before its result is registered. One request at a time;
//   in_stall stays high from acceptance until the block is idle again.
// Stall:
//   The result sits in an output register. The next request may be taken
//   while it waits; that request holds in its commit cycle until the old
//   result is taken.
// Reset:
//   rst_n clears the valid bits, the clock and all control; memory contents
//   need no clearing since an entry's contents are used only while its valid bit is set.
module cursor_slot_lru_cache_core
    import csl_pkg::*;
#(
    parameter int SLOTS      = 4,
    parameter int ID_BITS    = 16,
    parameter int STAMP_BITS = 32,
    localparam int SLOT_W    = (SLOTS > 2) ? $clog2(SLOTS) : 1
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [1:0]                action,
    input  logic [ID_BITS-1:0]        cursor_id,
    input  logic                      large_req,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [SLOT_W-1:0]         slot,
    output logic                      hit,
    output logic                      load_needed,
    output logic                      flushed_all,
    output logic                      evicted_valid,
    output logic [ID_BITS-1:0]        evicted_id
);

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

    // control
    state_t state_reg, state_next;
    logic   rd_en;
    logic   commit_fire;
    logic   in_fire;
    logic   out_fire;

    // latched request
    logic [1:0]         act_reg;
    logic [ID_BITS-1:0] id_reg;
    logic               large_reg;

    // scan state
    logic [SLOT_W-1:0]     cnt_reg;
    logic                  rd_pend_reg;
    logic [SLOT_W-1:0]     rd_idx_reg;
    logic                  found_reg;
    logic [SLOT_W-1:0]     hit_idx_reg;
    logic                  empty_found_reg;
    logic [SLOT_W-1:0]     empty_idx_reg;
    logic                  best_seen_reg;
    logic [SLOT_W-1:0]     best_idx_reg;
    logic [STAMP_BITS-1:0] best_stamp_reg;
    logic [ID_BITS-1:0]    best_owner_reg;

    // slot state in flops
    logic [SLOTS-1:0]      valid_reg;
    logic [STAMP_BITS-1:0] clock_reg;

    // memory read data
    logic [ID_BITS-1:0]    rd_owner;
    logic [STAMP_BITS-1:0] rd_stamp;
    logic                  rd_slot_valid;

    // commit decode
    logic [SLOT_W-1:0]     c_slot;
    logic                  c_hit;
    logic                  c_load;
    logic                  c_flush;
    logic                  c_ev;
    logic [ID_BITS-1:0]    c_evid;
    logic                  c_wr;
    logic [STAMP_BITS-1:0] c_stamp;
    logic [SLOTS-1:0]      c_valid;

    // result register
    logic                  out_valid_reg;
    logic [SLOT_W-1:0]     slot_reg;
    logic                  hit_reg;
    logic                  load_reg;
    logic                  flush_reg;
    logic                  ev_reg;
    logic [ID_BITS-1:0]    evid_reg;

    csl_slot_mem #(
        .SLOTS      (SLOTS),
        .ID_BITS    (ID_BITS),
        .STAMP_BITS (STAMP_BITS),
        .SLOT_W     (SLOT_W)
    ) u_mem (
        .clk      (clk),
        .wr_en    (commit_fire && c_wr),
        .wr_addr  (c_slot),
        .wr_owner (id_reg),
        .wr_stamp (c_stamp),
        .rd_en    (rd_en),
        .rd_addr  (cnt_reg),
        .rd_owner (rd_owner),
        .rd_stamp (rd_stamp)
    );

    // ---------------- state machine ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (cnt_reg == LAST_SLOT)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
                state_next = ST_COMMIT;
            ST_COMMIT:
            begin
                if (!out_valid_reg || !out_stall)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall    = (state_reg != ST_IDLE);
        rd_en       = (state_reg == ST_SCAN);
        commit_fire = (state_reg == ST_COMMIT) && (!out_valid_reg || !out_stall);
    end

    assign in_fire  = in_valid && !in_stall;
    assign out_fire = out_valid_reg && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // ---------------- request latch ----------------
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            act_reg   <= action;
            id_reg    <= cursor_id;
            large_reg <= large_req;
        end
    end

    // ---------------- slot scan ----------------
    // Read data for slot rd_idx_reg arrives in the cycle after its address.
    assign rd_slot_valid = valid_reg[rd_idx_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg         <= '0;
            rd_pend_reg     <= 1'b0;
            rd_idx_reg      <= '0;
            found_reg       <= 1'b0;
            empty_found_reg <= 1'b0;
            best_seen_reg   <= 1'b0;
            hit_idx_reg     <= '0;
            empty_idx_reg   <= '0;
            best_idx_reg    <= '0;
        end
        else
        begin
            rd_pend_reg <= rd_en;
            rd_idx_reg  <= cnt_reg;
            if (in_fire)
            begin
                cnt_reg         <= '0;
                found_reg       <= 1'b0;
                empty_found_reg <= 1'b0;
                best_seen_reg   <= 1'b0;
            end
            else if (rd_en)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end

            if (rd_pend_reg)
            begin
                if (rd_slot_valid && (rd_owner == id_reg) && !found_reg)
                begin
                    found_reg   <= 1'b1;
                    hit_idx_reg <= rd_idx_reg;
                end
                if (!rd_slot_valid && !empty_found_reg)
                begin
                    empty_found_reg <= 1'b1;
                    empty_idx_reg   <= rd_idx_reg;
                end
                // oldest stamp, later slot wins ties
                if (rd_slot_valid && (!best_seen_reg || (rd_stamp <= best_stamp_reg)))
                begin
                    best_seen_reg <= 1'b1;
                    best_idx_reg  <= rd_idx_reg;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_pend_reg && rd_slot_valid &&
            (!best_seen_reg || (rd_stamp <= best_stamp_reg)))
        begin
            best_stamp_reg <= rd_stamp;
            best_owner_reg <= rd_owner;
        end
    end

    // ---------------- commit decode ----------------
    always_comb
    begin
        c_slot  = '0;
        c_hit   = 1'b0;
        c_load  = 1'b0;
        c_flush = 1'b0;
        c_ev    = 1'b0;
        c_evid  = '0;
        c_wr    = 1'b0;
        c_stamp = clock_reg;
        c_valid = valid_reg;
        unique case (act_reg)
            ACT_SHOW:
            begin
                if (found_reg)
                begin
                    c_slot = hit_idx_reg;
                    c_hit  = 1'b1;
                end
                else if (large_reg)
                begin
                    // large cursor takes the whole cursor RAM, clock restarts
                    c_valid = '0;
                    c_stamp = '0;
                    c_flush = 1'b1;
                    c_load  = 1'b1;
                end
                else if (empty_found_reg)
                begin
                    c_slot = empty_idx_reg;
                    c_load = 1'b1;
                end
                else
                begin
                    c_slot = best_idx_reg;
                    c_load = 1'b1;
                    c_ev   = 1'b1;
                    c_evid = best_owner_reg;
                end
                c_wr            = 1'b1;
                c_valid[c_slot] = 1'b1;
            end
            ACT_RELEASE:
            begin
                if (found_reg)
                begin
                    c_valid[hit_idx_reg] = 1'b0;
                    c_hit                = 1'b1;
                end
            end
            ACT_FLUSH:
            begin
                c_valid = '0;
                c_flush = 1'b1;
            end
            default:
            begin
                c_valid = valid_reg;
            end
        endcase
    end

    // stamps of freed slots are never consulted, so they are not cleared
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            clock_reg <= '0;
        end
        else if (commit_fire)
        begin
            valid_reg <= c_valid;
            if (c_wr)
                clock_reg <= STAMP_BITS'(c_stamp + 1'b1);
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (commit_fire)
            out_valid_reg <= 1'b1;
        else if (out_fire)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (commit_fire)
        begin
            slot_reg  <= c_slot;
            hit_reg   <= c_hit;
            load_reg  <= c_load;
            flush_reg <= c_flush;
            ev_reg    <= c_ev;
            evid_reg  <= c_evid;
        end
    end

    assign out_valid     = out_valid_reg;
    assign slot          = slot_reg;
    assign hit           = hit_reg;
    assign load_needed   = load_reg;
    assign flushed_all   = flush_reg;
    assign evicted_valid = ev_reg;
    assign evicted_id    = evid_reg;

    // ---------------- assertions ----------------
    a_result_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == ST_COMMIT))
        else $error("result raised outside commit");

    a_accept_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == ST_SCAN && cnt_reg == '0))
        else $error("accepted request did not start a scan");

    a_hit_no_load: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(hit && load_needed))
        else $error("hit and load_needed both set");

    a_evict_is_small_load: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && evicted_valid) |-> (load_needed && !flushed_all && !hit))
        else $error("eviction reported without a small load");

    a_no_commit_over_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> $stable(slot) && $stable(evicted_id))
        else $error("waiting result overwritten");

endmodule

[src/csl_slot_mem.sv]
// Slot table memory: owner id and stamp per slot, one write and one registered read port.
module csl_slot_mem
    import csl_pkg::*;
#(
    parameter int SLOTS      = 4,
    parameter int ID_BITS    = 16,
    parameter int STAMP_BITS = 32,
    parameter int SLOT_W     = 2
)
(
    input  logic                  clk,
    input  logic                  wr_en,
    input  logic [SLOT_W-1:0]     wr_addr,
    input  logic [ID_BITS-1:0]    wr_owner,
    input  logic [STAMP_BITS-1:0] wr_stamp,
    input  logic                  rd_en,
    input  logic [SLOT_W-1:0]     rd_addr,
    output logic [ID_BITS-1:0]    rd_owner,
    output logic [STAMP_BITS-1:0] rd_stamp
);

    logic [ID_BITS-1:0]    owner_mem [SLOTS];
    logic [STAMP_BITS-1:0] stamp_mem [SLOTS];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            owner_mem[wr_addr] <= wr_owner;
            stamp_mem[wr_addr] <= wr_stamp;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_owner <= owner_mem[rd_addr];
            rd_stamp <= stamp_mem[rd_addr];
        end
    end

endmodule

[test/cursor_slot_checker.sv]
// Checker for the cursor slot cache: watches both channels, predicts each result word, compares.
`timescale 1ns / 100ps

module cursor_slot_checker
    import csl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [1:0]  action,
    input  logic [15:0] cursor_id,
    input  logic        large_req,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [1:0]  slot,
    input  logic        hit,
    input  logic        load_needed,
    input  logic        flushed_all,
    input  logic        evicted_valid,
    input  logic [15:0] evicted_id,
    output int          fail_count,
    output int          pending,
    output int          results_seen,
    output int          hits_seen,
    output int          evicts_seen,
    output int          flushes_seen
);

    localparam int NSLOT = 4;

    typedef struct packed {
        logic [1:0]  slot;
        logic        hit;
        logic        load;
        logic        flush;
        logic        ev_valid;
        logic [15:0] ev_id;
    } slot_result_t;

    // shadow copy of the slot table
    logic        line_valid [NSLOT];
    logic [15:0] line_owner [NSLOT];
    logic [31:0] line_stamp [NSLOT];
    logic [31:0] show_clock;

    slot_result_t due_q [$];
    slot_result_t due;

    function automatic void clear_lines();
        for (int i = 0; i < NSLOT; i++)
        begin
            line_valid[i] = 1'b0;
            line_stamp[i] = '0;
        end
    endfunction

    // Applies one request word to the shadow table and returns the word the block owes.
    function automatic slot_result_t predict_cursor_slot(logic [1:0] act, logic [15:0] id,
                                                         logic big);
        slot_result_t r;
        int           found;
        int           pick;
        logic [31:0]  oldest;
        r = '0;
        found = -1;
        for (int i = NSLOT - 1; i >= 0; i--)
            if (line_valid[i] && line_owner[i] == id)
                found = i;
        case (act)
            ACT_SHOW:
            begin
                if (found >= 0)
                begin
                    pick = found;
                    r.hit = 1'b1;
                end
                else if (big)
                begin
                    // a large cursor takes all cursor RAM: wipe and restart the clock
                    clear_lines();
                    show_clock = '0;
                    pick = 0;
                    r.flush = 1'b1;
                    r.load = 1'b1;
                end
                else
                begin
                    pick = -1;
                    for (int i = NSLOT - 1; i >= 0; i--)
                        if (!line_valid[i])
                            pick = i;
                    if (pick < 0)
                    begin
                        // oldest stamp, later index wins a tie
                        pick = 0;
                        oldest = line_stamp[0];
                        for (int i = 1; i < NSLOT; i++)
                            if (line_stamp[i] <= oldest)
                            begin
                                pick = i;
                                oldest = line_stamp[i];
                            end
                        r.ev_valid = 1'b1;
                        r.ev_id = line_owner[pick];
                    end
                    r.load = 1'b1;
                end
                line_valid[pick] = 1'b1;
                line_owner[pick] = id;
                line_stamp[pick] = show_clock;
                show_clock = show_clock + 32'd1;
                r.slot = pick[1:0];
            end
            ACT_RELEASE:
            begin
                if (found >= 0)
                begin
                    line_valid[found] = 1'b0;
                    line_stamp[found] = '0;
                    r.hit = 1'b1;
                end
            end
            ACT_FLUSH:
            begin
                clear_lines();
                r.flush = 1'b1;
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got)
        begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NSLOT; i++)
            begin
                line_valid[i] = 1'b0;
                line_owner[i] = '0;
                line_stamp[i] = '0;
            end
            show_clock = '0;
            due_q.delete();
            fail_count = 0;
            pending = 0;
            results_seen = 0;
            hits_seen = 0;
            evicts_seen = 0;
            flushes_seen = 0;
        end
        else
        begin
            // result side first; a word taken now cannot belong to this edge's request
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (due_q.size() == 0)
                begin
                    $error("result word arrived with nothing outstanding");
                    fail_count++;
                end
                else
                begin
                    due = due_q.pop_front();
                    check_field("slot", 16'(due.slot), 16'(slot));
                    check_field("hit", 16'(due.hit), 16'(hit));
                    check_field("load_needed", 16'(due.load), 16'(load_needed));
                    check_field("flushed_all", 16'(due.flush), 16'(flushed_all));
                    check_field("evicted_valid", 16'(due.ev_valid), 16'(evicted_valid));
                    check_field("evicted_id", due.ev_id, evicted_id);
                end
            end
            if (in_valid && !in_stall)
            begin
                due = predict_cursor_slot(action, cursor_id, large_req);
                hits_seen += due.hit;
                evicts_seen += due.ev_valid;
                flushes_seen += due.flush;
                due_q.push_back(due);
            end
            pending = due_q.size();
        end
    end

endmodule

[test/tb_cursor_slot_lru_cache_core.sv]
// Testbench top for the cursor slot cache: clock, reset, request stimulus, sink stalls, verdict.
`timescale 1ns / 100ps

module tb_cursor_slot_lru_cache_core;
    import csl_pkg::*;

    // code the block must treat as a no-op
    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int RAND_WORDS  = 1930;
    localparam int CALM_WORDS  = 300;   // tail of the run with no idling at all
    localparam int PHASE_WORDS = 250;
    localparam int QUIET_LIMIT = 2000;  // cycles with no handshake before we give up
    localparam int POOL_SIZE   = 6;     // a few more ids than slots, so misses evict

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  action;
    logic [15:0] cursor_id;
    logic        large_req;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  slot;
    logic        hit;
    logic        load_needed;
    logic        flushed_all;
    logic        evicted_valid;
    logic [15:0] evicted_id;

    int fail_count;
    int pending;
    int results_seen;
    int hits_seen;
    int evicts_seen;
    int flushes_seen;

    // idling controls, switched per phase by the stimulus
    logic gap_on;
    logic stall_on;
    int   words_sent;
    int   quiet_cycles;

    cursor_slot_lru_cache_core DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .action        (action),
        .cursor_id     (cursor_id),
        .large_req     (large_req),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .slot          (slot),
        .hit           (hit),
        .load_needed   (load_needed),
        .flushed_all   (flushed_all),
        .evicted_valid (evicted_valid),
        .evicted_id    (evicted_id)
    );

    cursor_slot_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .action        (action),
        .cursor_id     (cursor_id),
        .large_req     (large_req),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .slot          (slot),
        .hit           (hit),
        .load_needed   (load_needed),
        .flushed_all   (flushed_all),
        .evicted_valid (evicted_valid),
        .evicted_id    (evicted_id),
        .fail_count    (fail_count),
        .pending       (pending),
        .results_seen  (results_seen),
        .hits_seen     (hits_seen),
        .evicts_seen   (evicts_seen),
        .flushes_seen  (flushes_seen)
    );

    initial
        clk = 1'b0;

    always #2 clk = ~clk;

    // Present one request word and hold it until the block takes it.
    // When gaps are on, valid may drop for a burst first; never while a word is pending.
    task automatic send_word(logic [1:0] act, logic [15:0] id, logic big);
        int gap;
        if (gap_on && $urandom_range(0, 2) == 0)
        begin
            gap = $urandom_range(1, 9);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        action    <= act;
        cursor_id <= id;
        large_req <= big;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        words_sent++;
    endtask

    // Result sink: random stall bursts while enabled.
    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall_on && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 9)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Watchdog: any handshake restarts the count.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("no handshake for %0d cycles", QUIET_LIMIT);
            $display("cursor_slot_lru_cache_core test failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        logic [15:0] id_pool [POOL_SIZE];
        logic [1:0]  act;
        logic [15:0] id;
        logic        big;
        int          roll;
        int          phase;

        rst_n        <= 1'b0;
        in_valid     <= 1'b0;
        action       <= ACT_SHOW;
        cursor_id    <= '0;
        large_req    <= 1'b0;
        gap_on       <= 1'b0;
        stall_on     <= 1'b0;
        words_sent   = 0;
        quiet_cycles = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed part ----
        // release on an empty table: a miss, nothing changes
        send_word(ACT_RELEASE, 16'h0000, 1'b0);
        // fill all four slots, lowest empty slot first; id extremes included
        send_word(ACT_SHOW, 16'h0000, 1'b0);
        send_word(ACT_SHOW, 16'hFFFF, 1'b0);
        send_word(ACT_SHOW, 16'h1234, 1'b0);
        send_word(ACT_SHOW, 16'hABCD, 1'b0);
        // hit with the large flag set: flag ignored, slot just restamped
        send_word(ACT_SHOW, 16'h0000, 1'b1);
        // full table, small miss: oldest (16'hFFFF in slot 1) goes
        send_word(ACT_SHOW, 16'h5555, 1'b0);
        // release a resident id, then refill the hole it leaves
        send_word(ACT_RELEASE, 16'h1234, 1'b0);
        send_word(ACT_SHOW, 16'h7777, 1'b0);
        // release of an id that is not there
        send_word(ACT_RELEASE, 16'h9999, 1'b1);
        // unused code: every output field zero, no state change
        send_word(ACT_UNUSED, 16'hFFFF, 1'b1);
        send_word(ACT_SHOW, 16'h7777, 1'b0);
        // flush keeps the clock; next show lands in slot 0
        send_word(ACT_FLUSH, 16'h0000, 1'b0);
        send_word(ACT_SHOW, 16'hAAAA, 1'b0);
        send_word(ACT_SHOW, 16'h5555, 1'b0);
        // large miss wipes the table and restarts the clock
        send_word(ACT_SHOW, 16'h0001, 1'b1);
        send_word(ACT_SHOW, 16'h0002, 1'b0);
        send_word(ACT_SHOW, 16'h0001, 1'b1);
        send_word(ACT_FLUSH, 16'hFFFF, 1'b1);
        send_word(ACT_RELEASE, 16'hFFFF, 1'b0);
        // large miss on an already empty table
        send_word(ACT_SHOW, 16'hFFFF, 1'b1);
        send_word(ACT_SHOW, 16'h8000, 1'b0);

        // ---- random part ----
        // Mostly shows from a small id pool so hits, LRU evictions and releases
        // of resident ids are common; a few full-range ids, flushes and unused codes.
        for (int n = 0; n < RAND_WORDS; n++)
        begin
            if (n % PHASE_WORDS == 0)
            begin
                // walk through every mix of source gaps and sink stalls
                phase = n / PHASE_WORDS + 1;
                gap_on   <= phase[0];
                stall_on <= phase[1];
            end
            if (n == RAND_WORDS - CALM_WORDS)
            begin
                gap_on   <= 1'b0;
                stall_on <= 1'b0;
            end
            if (n % 200 == 0)
                for (int k = 0; k < POOL_SIZE; k++)
                    id_pool[k] = 16'($urandom);
            if ($urandom_range(0, 9) == 0)
                id = 16'($urandom);
            else
                id = id_pool[$urandom_range(0, POOL_SIZE - 1)];
            big  = 1'($urandom);
            roll = $urandom_range(0, 99);
            if (roll < 70)
            begin
                act = ACT_SHOW;
                // large misses wipe the table, keep them rare
                big = ($urandom_range(0, 19) == 0);
            end
            else if (roll < 88)
                act = ACT_RELEASE;
            else if (roll < 96)
                act = ACT_FLUSH;
            else
                act = ACT_UNUSED;
            send_word(act, id, big);
        end
        in_valid <= 1'b0;

        // drain, then a margin for stray words
        @(posedge clk);
        wait (pending == 0);
        repeat (20) @(posedge clk);

        $display("sent %0d request words, checked %0d result words", words_sent, results_seen);
        $display("covered %0d hits, %0d LRU evictions, %0d full-table wipes",
                 hits_seen, evicts_seen, flushes_seen);
        if (fail_count == 0)
            $display("cursor_slot_lru_cache_core test passed");
        else
            $display("cursor_slot_lru_cache_core test failed");
        $finish;
    end

endmodule
